FILE: rtl/core/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

    localparam int NUM_PINS = 30;
    localparam int ROW_CAP  = 30;
    localparam int PIN_W    = 30;
    localparam int ROWS     = (NUM_PINS < ROW_CAP) ? NUM_PINS : ROW_CAP;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 8;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [PIN_W-1:0] PIN_MASK =
        PIN_W'(((64'd1 << NUM_PINS) - 64'd1) & ((64'd1 << PIN_W) - 64'd1));
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int S_TDATA_W = ((IDX_W + PIN_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * IDX_W + 2 + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STUCK_PINS   = 3'd0,
        REG_STABLE_SCANS = 3'd1,
        REG_LEARN_WINDOW = 3'd2,
        REG_LED_HOLD     = 3'd3,
        REG_BOOT_HOLD    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_HOLD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [PIN_W-1:0] debounced;
        logic [PIN_W-1:0] baseline;
        logic [CNT_W-1:0] count;
    } row_t;

    // command from the scan controller to the result emitter
    typedef struct packed {
        logic             load;
        logic [PIN_W-1:0] rising;
        logic [IDX_W-1:0] drive_pin;
        logic             status;
        logic             led;
        logic             boot;
    } emit_cmd_t;

    // index of the lowest set bit; zero when none set
    function automatic logic [IDX_W-1:0] lowest_index(input logic [PIN_W-1:0] v);
        logic [PIN_W-1:0] one_hot;
        logic [IDX_W-1:0] idx;
        one_hot = v & (~v + PIN_W'(1));
        idx = '0;
        for (int i = 0; i < PIN_W; i++) begin
            if (one_hot[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/core/pps_row_store.sv
`timescale 1ns / 1ps

module pps_row_store (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [pps_pkg::IDX_W-1:0] rd_addr,
    output pps_pkg::row_t            rd_data,
    input  logic                     wr_en,
    input  logic [pps_pkg::IDX_W-1:0] wr_addr,
    input  pps_pkg::row_t            wr_data
);

    pps_pkg::row_t mem [pps_pkg::ROWS];
    logic [pps_pkg::ROWS-1:0] valid_reg;
    pps_pkg::row_t rd_word_reg;
    logic rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // a row never written reads as its reset value
    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en))
        else $error("row store read and write in the same cycle");

endmodule

FILE: rtl/core/pps_event_emitter.sv
`timescale 1ns / 1ps

module pps_event_emitter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pps_pkg::emit_cmd_t            cmd,
    output logic                          busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [4:0] event_drive_pin, [9:5] event_sense_pin, [10] led_test_request,
    // [11] boot_request, [15:12] zero
    output logic [pps_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] is_status
    output logic                          m_tuser,
    output logic                          m_tlast
);

    logic [pps_pkg::PIN_W-1:0] pend_reg, pend_next;
    logic                      status_pend_reg, status_pend_next;
    logic [pps_pkg::IDX_W-1:0] drive_reg;
    logic                      led_reg, boot_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [pps_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                      out_user_reg, out_user_next;
    logic                      out_last_reg, out_last_next;

    logic                      out_free;
    logic [pps_pkg::IDX_W-1:0] sense_idx;
    logic [pps_pkg::PIN_W-1:0] pend_cleared;

    assign out_free     = !out_valid_reg || m_tready;
    assign sense_idx    = pps_pkg::lowest_index(pend_reg);
    assign pend_cleared = pend_reg & (pend_reg - pps_pkg::PIN_W'(1));

    always_comb begin
        pend_next        = pend_reg;
        status_pend_next = status_pend_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;
        out_last_next    = out_last_reg;
        if (cmd.load) begin
            pend_next        = cmd.rising;
            status_pend_next = cmd.status;
        end else if (out_free && pend_reg != '0) begin
            out_valid_next = 1'b1;
            out_user_next  = 1'b0;
            out_data_next  = pps_pkg::M_TDATA_W'({sense_idx, drive_reg});
            out_last_next  = (pend_cleared == '0) && !status_pend_reg;
            pend_next      = pend_cleared;
        end else if (out_free && status_pend_reg) begin
            out_valid_next   = 1'b1;
            out_user_next    = 1'b1;
            out_data_next    = pps_pkg::M_TDATA_W'({boot_reg, led_reg,
                                   {(2 * pps_pkg::IDX_W){1'b0}}});
            out_last_next    = 1'b1;
            status_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg        <= '0;
            status_pend_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            pend_reg        <= pend_next;
            status_pend_reg <= status_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
        if (cmd.load) begin
            drive_reg <= cmd.drive_pin;
            led_reg   <= cmd.led;
            boot_reg  <= cmd.boot;
        end
    end

    assign busy     = (pend_reg != '0) || status_pend_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status item without tlast");

    a_pair_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[4:0] != m_tdata[9:5])
        else $error("press event pairs a pin with itself");

    a_load_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !busy)
        else $error("emitter loaded while results pending");

endmodule

FILE: rtl/core/pin_pair_scan_debouncer.sv
`timescale 1ns / 1ps

// Debouncer for a pin-pair key matrix read one driven row per item. Each row
// keeps its debounced bitmap, learned baseline and change counter in a 30-row
// synchronous RAM that is read, updated and written back once per item; reset
// clears per-row valid bits, so no clearing pass is needed. For each accepted
// item the accept cycle issues the RAM read, state ST_UPDATE does the row
// update and write-back, and ST_HOLD does hold tracking and loads the emitter
// with the results (press events plus the status item on end of scan). Then
// one result per cycle goes into the output register while it is empty or
// m_tready is high, and ST_EMIT waits until the emitter is drained; a result
// waits while m_tready is low and the output register is full. s_tready
// rises in the cycle after the last result of the previous item has entered
// the output register.
// Configuration writes take effect at once and are meant for idle periods.

module pin_pair_scan_debouncer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [4:0] drive_pin, [34:5] pin_levels, [66:35] now_ms, [71:67] zero
    input  logic [pps_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [4:0] event_drive_pin, [9:5] event_sense_pin, [10] led_test_request,
    // [11] boot_request, [15:12] zero
    output logic [pps_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] is_status
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pps_pkg::PIN_W-1:0]         cfg_wdata
);

    localparam int IW = pps_pkg::IDX_W;
    localparam int PW = pps_pkg::PIN_W;
    localparam int TW = pps_pkg::TIME_W;
    localparam int MW = pps_pkg::MS_W;
    localparam int CW = pps_pkg::CNT_W;

    // configuration
    logic [PW-1:0] stuck_reg;
    logic [CW-1:0] stable_reg;
    logic [MW-1:0] learn_reg, led_ms_reg, boot_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stuck_reg   <= '0;
            stable_reg  <= CW'(8);
            learn_reg   <= MW'(1500);
            led_ms_reg  <= MW'(3000);
            boot_ms_reg <= MW'(10000);
        end else if (cfg_we) begin
            unique case (cfg_index)
                pps_pkg::REG_STUCK_PINS:   stuck_reg   <= cfg_wdata;
                pps_pkg::REG_STABLE_SCANS: stable_reg  <= cfg_wdata[CW-1:0];
                pps_pkg::REG_LEARN_WINDOW: learn_reg   <= cfg_wdata[MW-1:0];
                pps_pkg::REG_LED_HOLD:     led_ms_reg  <= cfg_wdata[MW-1:0];
                pps_pkg::REG_BOOT_HOLD:    boot_ms_reg <= cfg_wdata[MW-1:0];
                default: ;
            endcase
        end
    end

    pps_pkg::state_t state_reg, state_next;

    logic          s_accept;
    logic [IW-1:0] in_pin;
    logic          in_row_ok;

    logic [IW-1:0] pin_reg;
    logic [PW-1:0] levels_reg;
    logic [TW-1:0] now_reg;
    logic          eos_reg;
    logic          row_ok_reg;

    logic [PW-1:0] active_reg, active_next;
    logic          holding_reg, holding_next;
    logic [TW-1:0] hold_start_reg, hold_start_next;
    logic [PW-1:0] rising_reg, rising_next;

    pps_pkg::row_t rd_row, wr_row;
    logic          wr_en;
    logic          emit_busy;
    pps_pkg::emit_cmd_t cmd;

    assign in_pin    = s_tdata[IW-1:0];
    assign in_row_ok = {1'b0, in_pin} < (IW + 1)'(pps_pkg::ROWS);
    assign s_accept  = s_tvalid && s_tready;

    pps_row_store u_rows (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept && in_row_ok),
        .rd_addr (in_pin),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (pin_reg),
        .wr_data (wr_row)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pin_reg    <= in_pin;
            levels_reg <= s_tdata[IW +: PW];
            now_reg    <= s_tdata[IW + PW +: TW];
            eos_reg    <= s_tlast;
            row_ok_reg <= in_row_ok;
        end
    end

    // row update
    logic          learning;
    logic [PW-1:0] pin_bit, raw, clean;
    logic [CW-1:0] cnt_inc;

    assign learning = now_reg < TW'(learn_reg);

    always_comb begin
        pin_bit = PW'(1) << pin_reg;
        raw = '0;
        if ((stuck_reg & pin_bit) == '0) begin
            raw = levels_reg & pps_pkg::PIN_MASK & ~pin_bit & ~stuck_reg;
        end
        clean   = raw & ~rd_row.baseline;
        cnt_inc = (rd_row.count == pps_pkg::CNT_MAX) ? rd_row.count
                                                     : rd_row.count + CW'(1);
        wr_row      = rd_row;
        rising_next = '0;
        if (learning) begin
            wr_row.baseline  = rd_row.baseline | raw;
            wr_row.debounced = '0;
        end else if (clean != rd_row.debounced) begin
            if (cnt_inc >= stable_reg) begin
                rising_next      = clean & ~rd_row.debounced;
                wr_row.debounced = clean;
                wr_row.count     = '0;
            end else begin
                wr_row.count = cnt_inc;
            end
        end else begin
            wr_row.count = '0;
        end
        active_next = active_reg;
        if (state_reg == pps_pkg::ST_UPDATE && row_ok_reg) begin
            active_next = (wr_row.debounced != '0) ? (active_reg | pin_bit)
                                                   : (active_reg & ~pin_bit);
        end
    end

    // hold tracking at end of scan
    logic          any_active, holding_eff, hold_led, hold_boot, hold_run;
    logic [TW-1:0] start_eff, held;

    always_comb begin
        any_active      = active_reg != '0;
        holding_eff     = holding_reg || any_active;
        start_eff       = holding_reg ? hold_start_reg : now_reg;
        held            = now_reg - start_eff;
        hold_run        = state_reg == pps_pkg::ST_HOLD && eos_reg && !learning;
        hold_boot       = hold_run && holding_eff && (held > TW'(boot_ms_reg));
        hold_led        = hold_run && holding_eff && !any_active
                          && (held >= TW'(led_ms_reg));
        holding_next    = holding_reg;
        hold_start_next = hold_start_reg;
        if (hold_run) begin
            holding_next    = holding_eff && any_active;
            hold_start_next = start_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pps_pkg::ST_IDLE;
            active_reg     <= '0;
            holding_reg    <= 1'b0;
            hold_start_reg <= '0;
        end else begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            holding_reg    <= holding_next;
            hold_start_reg <= hold_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == pps_pkg::ST_UPDATE) begin
            rising_reg <= row_ok_reg ? rising_next : '0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pps_pkg::ST_IDLE:   if (s_accept) state_next = pps_pkg::ST_UPDATE;
            pps_pkg::ST_UPDATE: state_next = pps_pkg::ST_HOLD;
            pps_pkg::ST_HOLD:   state_next = pps_pkg::ST_EMIT;
            pps_pkg::ST_EMIT:   if (!emit_busy) state_next = pps_pkg::ST_IDLE;
            default:            state_next = pps_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        wr_en    = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            pps_pkg::ST_IDLE:   s_tready = 1'b1;
            pps_pkg::ST_UPDATE: wr_en = row_ok_reg;
            pps_pkg::ST_HOLD: begin
                cmd.load      = 1'b1;
                cmd.rising    = rising_reg;
                cmd.drive_pin = pin_reg;
                cmd.status    = eos_reg;
                cmd.led       = hold_led;
                cmd.boot      = hold_boot;
            end
            pps_pkg::ST_EMIT:   ;
            default:            ;
        endcase
    end

    pps_event_emitter u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_busy |-> !s_tready)
        else $error("item accepted while results pending");

    a_hold_only_outside_learning: assert property (@(posedge aclk)
        disable iff (!aresetn)
        holding_reg != $past(holding_reg) |-> $past(hold_run))
        else $error("hold state changed without end-of-scan tracking");

endmodule
